FILE: hw/rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the pressure/temperature compensation
// Field widths, register indexes and the fixed constants of the integer scheme.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RawW   = 20;
  localparam int OutW   = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam int DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_COEFFS = 2'd0,
    REG_PRESS_LOW   = 2'd1,
    REG_PRESS_HIGH  = 2'd2,
    REG_PRESS_NINE  = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressFull   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] DivHalf     = 32'h8000_0000;
  localparam logic [31:0] P1Bias      = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } ptc_in_t;

  typedef struct packed {
    logic [OutW-1:0] temperature_centi;
    logic [OutW-1:0] pressure_pa;
    logic            pressure_fault;
  } ptc_out_t;

endpackage

FILE: hw/rtl/ptc_if.sv
// ----------------------------------------------------------------------------
// ptc_if: valid/ready channel
// Carries one payload request with valid and ready.
// ----------------------------------------------------------------------------
interface ptc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: 32-bit integer barometric compensation
// Raw 20-bit temperature and pressure in, hundredths of a degree and pascals
// out, with a fault flag when the pressure divisor is zero.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  in_ch     | sink      | raw_temperature, raw_pressure
//  out_ch    | source    | temperature_centi, pressure_pa, pressure_fault
//  cfg_*     | write     | cfg_we, cfg_index, cfg_data
//
// One request a cycle enters while the output is not stalled; the
// restoring divider takes one quotient bit per stage.
// Reset clears all valid bits and coefficient registers.
// A stall at the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ptc_pkg::CfgDataW-1:0]  cfg_data,
  ptc_if.sink                           in_ch,
  ptc_if.source                         out_ch
);
  import ptc_pkg::*;

  localparam int PreN  = 10;           // stages before the divider
  localparam int PostN = 3;            // stages after the divider
  localparam int N     = PreN + DivSteps + PostN;

  // Coefficient registers.
  logic [47:0] temp_coeffs;
  logic [63:0] press_low, press_high;
  logic [15:0] press_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_low   <= '0;
      press_high  <= '0;
      press_nine  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_COEFFS: temp_coeffs <= cfg_data[47:0];
        REG_PRESS_LOW:   press_low   <= cfg_data;
        REG_PRESS_HIGH:  press_high  <= cfg_data;
        REG_PRESS_NINE:  press_nine  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    sra = 32'($signed(x) >>> n);
  endfunction

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = sx(temp_coeffs[31:16]);
  assign t3 = sx(temp_coeffs[47:32]);
  assign p1 = {16'd0, press_low[15:0]};
  assign p2 = sx(press_low[31:16]);
  assign p3 = sx(press_low[47:32]);
  assign p4 = sx(press_low[63:48]);
  assign p5 = sx(press_high[15:0]);
  assign p6 = sx(press_high[31:16]);
  assign p7 = sx(press_high[47:32]);
  assign p8 = sx(press_high[63:48]);
  assign p9 = sx(press_nine);

  // Global advance: the pipeline moves when the output slot is free.
  logic adv;
  logic [N-1:0] vld;
  assign adv = !vld[N-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[N-2:0], in_ch.valid};
  end

  // Stage 0: capture and first differences.
  logic [31:0] s0_dt, s0_d, s0_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dt  <= {15'd0, in_ch.data.raw_temperature[RawW-1:3]} - (t1 << 1);
      s0_d   <= {16'd0, in_ch.data.raw_temperature[RawW-1:4]} - t1;
      s0_adp <= PressFull - {12'd0, in_ch.data.raw_pressure};
    end
  end

  // Stage 1: t2 and square products.
  logic [31:0] s1_m, s1_sq, s1_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m   <= s0_dt * t2;
      s1_sq  <= s0_d * s0_d;
      s1_adp <= s0_adp;
    end
  end

  // Stage 2: t3 product.
  logic [31:0] s2_a, s2_m, s2_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a   <= sra(s1_m, 11);
      s2_m   <= sra(s1_sq, 12) * t3;
      s2_adp <= s1_adp;
    end
  end

  // Stage 3: fine temperature and pressure offset.
  logic [31:0] s3_fine, s3_a, s3_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fine <= s2_a + sra(s2_m, 14);
      s3_a    <= sra(s2_a + sra(s2_m, 14), 1) - PressOffset;
      s3_adp  <= s2_adp;
    end
  end

  // Stage 4: temperature output and the first pressure products.
  logic [31:0] s4_temp, s4_a, s4_sq, s4_ap5, s4_p2a, s4_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_temp <= sra(s3_fine * 32'd5 + TempRound, 8);
      s4_a    <= s3_a;
      s4_sq   <= sra(s3_a, 2) * sra(s3_a, 2);
      s4_ap5  <= s3_a * p5;
      s4_p2a  <= p2 * s3_a;
      s4_adp  <= s3_adp;
    end
  end

  // Stage 5: square-term products.
  logic [31:0] s5_temp, s5_b6, s5_ap5, s5_p3, s5_p2a, s5_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_temp <= s4_temp;
      s5_b6   <= sra(s4_sq, 11) * p6;
      s5_ap5  <= s4_ap5;
      s5_p3   <= p3 * sra(s4_sq, 13);
      s5_p2a  <= s4_p2a;
      s5_adp  <= s4_adp;
    end
  end

  // Stage 6: b term and var1 before the p1 scaling.
  logic [31:0] s6_temp, s6_b, s6_a, s6_adp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_temp <= s5_temp;
      s6_b    <= sra(s5_b6 + (s5_ap5 << 1), 2) + (p4 << 16);
      s6_a    <= sra(sra(s5_p3, 3) + sra(s5_p2a, 1), 18);
      s6_adp  <= s5_adp;
    end
  end

  // Stage 7: divisor product and numerator difference.
  logic [31:0] s7_temp, s7_dm, s7_n;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_temp <= s6_temp;
      s7_dm   <= (P1Bias + s6_a) * p1;
      s7_n    <= s6_adp - sra(s6_b, 12);
    end
  end

  // Stage 8: divisor and scaled numerator.
  logic [31:0] s8_temp, s8_div, s8_n;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_temp <= s7_temp;
      s8_div  <= sra(s7_dm, 15);
      s8_n    <= s7_n * PressScale;
    end
  end

  // Stage 9: divider setup; large numerators divide first and double after.
  logic [31:0] s9_temp, s9_div, s9_num;
  logic        s9_dbl;
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_temp <= s8_temp;
      s9_div  <= s8_div;
      s9_dbl  <= !(s8_n < DivHalf);
      s9_num  <= (s8_n < DivHalf) ? (s8_n << 1) : s8_n;
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [31:0] dv_rem [DivSteps+1];
  logic [31:0] dv_num [DivSteps+1];
  logic [31:0] dv_div [DivSteps+1];
  logic [31:0] dv_tmp [DivSteps+1];
  logic        dv_dbl [DivSteps+1];

  assign dv_rem[0] = '0;
  assign dv_num[0] = s9_num;
  assign dv_div[0] = s9_div;
  assign dv_tmp[0] = s9_temp;
  assign dv_dbl[0] = s9_dbl;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [32:0] trial;
    assign trial = {dv_rem[g], dv_num[g][31]} - {1'b0, dv_div[g]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[g+1] <= trial[32] ? {dv_rem[g][30:0], dv_num[g][31]} : trial[31:0];
        dv_num[g+1] <= {dv_num[g][30:0], !trial[32]};
        dv_div[g+1] <= dv_div[g];
        dv_tmp[g+1] <= dv_tmp[g];
        dv_dbl[g+1] <= dv_dbl[g];
      end
    end
  end

  // Post stage 0: quotient, fault and correction products.
  logic [31:0] q0_temp, q0_p, q0_sq, q0_b;
  logic        q0_fault;
  logic [31:0] quo;
  assign quo = dv_dbl[DivSteps] ? (dv_num[DivSteps] << 1) : dv_num[DivSteps];
  always_ff @(posedge clk) begin
    if (adv) begin
      q0_temp  <= dv_tmp[DivSteps];
      q0_fault <= (dv_div[DivSteps] == '0);
      q0_p     <= quo;
      q0_sq    <= ({3'd0, quo[31:3]} * {3'd0, quo[31:3]}) >> 13;
      q0_b     <= {2'd0, quo[31:2]} * p8;
    end
  end

  // Post stage 1: p9 product.
  logic [31:0] q1_temp, q1_p, q1_a9, q1_b;
  logic        q1_fault;
  always_ff @(posedge clk) begin
    if (adv) begin
      q1_temp  <= q0_temp;
      q1_fault <= q0_fault;
      q1_p     <= q0_p;
      q1_a9    <= p9 * q0_sq;
      q1_b     <= sra(q0_b, 13);
    end
  end

  // Post stage 2: final pressure into the output register.
  ptc_out_t res;
  always_ff @(posedge clk) begin
    if (adv) begin
      res.temperature_centi <= q1_temp;
      res.pressure_fault    <= q1_fault;
      res.pressure_pa       <= q1_fault ? '0 : q1_p + sra(sra(q1_a9, 12) + q1_b + p7, 4);
    end
  end

  assign out_ch.valid = vld[N-1];
  assign out_ch.data  = res;

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  // Fault always reports zero pressure.
  a_fault: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.pressure_fault |-> out_ch.data.pressure_pa == '0)
    else $error("fault with nonzero pressure");
  // Input is refused only while a result waits.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without back pressure");

endmodule

FILE: sim/tb_pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation: self-checking bench for the
// 32-bit integer barometric compensation block.
// Raw temperature/pressure pairs are sent over the input channel under random
// idling and stalls, and each result is compared against a bench-side
// predictor of the integer scheme. The calibration registers are rewritten
// between phases: reset values, a typical calibration set, extremes and
// random sets.
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation;
  import ptc_pkg::*;

  localparam int Latency    = DivSteps + 13;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ptc_if #(.payload_t(ptc_in_t))  in_ch ();
  ptc_if #(.payload_t(ptc_out_t)) out_ch ();

  pressure_temperature_compensation dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Bench copy of the calibration registers.
  logic [47:0] temp_coeffs;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_nine;

  ptc_out_t expected_readings[$];
  int unsigned cycles;
  int unsigned errors;
  int unsigned requests_sent;
  int unsigned readings_checked;
  int unsigned faults_seen;
  bit sender_idles;
  bit receiver_idles;
  bit hold_request;
  int unsigned hold_left;
  int unsigned stall_left;
  logic sink_ready;

  assign out_ch.ready = sink_ready;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Predicts one compensated reading from the current register copy.
  function automatic ptc_out_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, sq, p, s;
    ptc_out_t r;
    adc_t = {12'd0, raw_t};
    adc_p = {12'd0, raw_p};
    t1 = {16'd0, temp_coeffs[15:0]};
    t2 = sx16(temp_coeffs[31:16]);
    t3 = sx16(temp_coeffs[47:32]);
    p1 = {16'd0, press_low[15:0]};
    p2 = sx16(press_low[31:16]);
    p3 = sx16(press_low[47:32]);
    p4 = sx16(press_low[63:48]);
    p5 = sx16(press_high[15:0]);
    p6 = sx16(press_high[31:16]);
    p7 = sx16(press_high[47:32]);
    p8 = sx16(press_high[63:48]);
    p9 = sx16(press_nine);
    // Temperature and the shared fine value.
    a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    s = asr(d * d, 12) * t3;
    b = asr(s, 14);
    fine = a + b;
    r.temperature_centi = asr(fine * 32'd5 + TempRound, 8);
    // Pressure divisor.
    a = asr(fine, 1) - PressOffset;
    q = asr(a, 2);
    sq = q * q;
    b = asr(sq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    s = p3 * asr(sq, 13);
    a = asr(asr(s, 3) + asr(p2 * a, 1), 18);
    a = asr((P1Bias + a) * p1, 15);
    if (a == 32'd0) begin
      r.pressure_fault = 1'b1;
      r.pressure_pa = 32'd0;
    end else begin
      r.pressure_fault = 1'b0;
      p = ((PressFull - adc_p) - asr(b, 12)) * PressScale;
      if (p < DivHalf) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      s = ((p >> 3) * (p >> 3)) >> 13;
      a = asr(p9 * s, 12);
      b = asr((p >> 2) * p8, 13);
      r.pressure_pa = p + asr(a + b + p7, 4);
    end
    return r;
  endfunction

  // Output side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      hold_left <= 0;
      stall_left <= 0;
    end else if (hold_request && hold_left == 0 && sink_ready) begin
      hold_left <= HoldCycles;
      sink_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      sink_ready <= (hold_left == 1);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 5);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading temp=%0d press=%0d fault=%0b", $time,
                 $signed(out_ch.data.temperature_centi), out_ch.data.pressure_pa,
                 out_ch.data.pressure_fault);
      end else begin
        ptc_out_t want;
        want = expected_readings.pop_front();
        readings_checked++;
        if (want.pressure_fault) faults_seen++;
        if (out_ch.data.temperature_centi !== want.temperature_centi) begin
          errors++;
          $display("%0t: temperature_centi expected %0d actual %0d", $time,
                   $signed(want.temperature_centi),
                   $signed(out_ch.data.temperature_centi));
        end
        if (out_ch.data.pressure_pa !== want.pressure_pa) begin
          errors++;
          $display("%0t: pressure_pa expected %0d actual %0d", $time,
                   want.pressure_pa, out_ch.data.pressure_pa);
        end
        if (out_ch.data.pressure_fault !== want.pressure_fault) begin
          errors++;
          $display("%0t: pressure_fault expected %0b actual %0b", $time,
                   want.pressure_fault, out_ch.data.pressure_fault);
        end
      end
    end
  end

  // Sends one request and records its expected reading at acceptance.
  task automatic send_pair(logic [19:0] raw_t, logic [19:0] raw_p);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{raw_temperature: raw_t, raw_pressure: raw_p};
    do @(posedge clk); while (!in_ch.ready);
    expected_readings.push_back(compensate(raw_t, raw_p));
    requests_sent++;
  endtask

  // Drops valid and waits until every reading is back and the pipe is empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_TEMP_COEFFS: temp_coeffs = value[47:0];
      REG_PRESS_LOW:   press_low = value;
      REG_PRESS_HIGH:  press_high = value;
      default:         press_nine = value[15:0];
    endcase
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                             logic [15:0] p9);
    drain();
    write_reg(REG_TEMP_COEFFS, {16'd0, tc});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_PRESS_NINE, {48'd0, p9});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 7))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      2, 3:    return 20'($urandom_range(0, 20'hFFFFF));
      default: return 20'($urandom_range(300000, 700000));
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Reset values: p1 is zero, so every reading carries the fault flag.
  task automatic test_reset_values();
    send_pair(20'd0, 20'd0);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'd519888, 20'd415148);
  endtask

  // Typical calibration with extreme and walking-bit raw readings.
  task automatic test_typical_calibration();
    load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    send_pair(20'd519888, 20'd415148);
    send_pair(20'd0, 20'hFFFFF);
    send_pair(20'hFFFFF, 20'd0);
    send_pair(20'hAAAAA, 20'h55555);
    send_pair(20'h55555, 20'hAAAAA);
    for (int i = 0; i < 20; i += 2) send_pair(20'd1 << i, 20'd1 << (19 - i));
  endtask

  // Coefficient extremes, including sets that wrap or zero the divisor.
  task automatic test_coeff_extremes();
    load_coeffs('1, '1, '1, 16'hFFFF);
    send_pair(20'hFFFFF, 20'hFFFFF);
    send_pair(20'd0, 20'd0);
    load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                {4{16'h8000}}, 16'h8000);
    send_pair(20'hFFFFF, 20'd0);
    send_pair(20'd0, 20'hFFFFF);
    load_coeffs({16'h7FFF, 16'h7FFF, 16'd1}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1},
                {4{16'h7FFF}}, 16'h7FFF);
    send_pair(20'd519888, 20'd415148);
    send_pair(20'hFFFFF, 20'hFFFFF);
  endtask

  // Random calibration sets, each followed by a batch of random readings.
  task automatic test_random_calibration(int sets, int per_set);
    logic [63:0] pl;
    for (int s = 0; s < sets; s++) begin
      pl = rand64();
      if (s % 3 == 0) pl[15:0] = 16'($urandom_range(20000, 40000));
      load_coeffs(48'(rand64()), pl, rand64(), 16'($urandom()));
      for (int i = 0; i < per_set; i++) send_pair(rand_raw(), rand_raw());
    end
  endtask

  // The output holds off for a long stretch while requests keep coming.
  task automatic test_output_hold();
    load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    hold_request = 1'b1;
    for (int i = 0; i < 120; i++) begin
      send_pair(rand_raw(), rand_raw());
      if (hold_left != 0) hold_request = 1'b0;
    end
    hold_request = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TEMP_COEFFS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    errors = 0;
    requests_sent = 0;
    readings_checked = 0;
    faults_seen = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_request = 1'b0;
    temp_coeffs = '0;
    press_low = '0;
    press_high = '0;
    press_nine = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_typical_calibration();
    test_coeff_extremes();
    test_output_hold();
    test_random_calibration(8, 100);
    // Last part runs at full rate on both sides.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_calibration(2, 90);
    drain();

    $display("Sent %0d requests, checked %0d readings (%0d with the fault flag),",
             requests_sent, readings_checked, faults_seen);
    $display("over reset, typical, extreme and random calibration sets; %0d errors.",
             errors);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
